[rtl/tsdt_pkg.sv]
// ----------------------------------------------------------------------------
// tsdt_pkg
// Shared types, codes and defaults of the thread syscall density table.
// ----------------------------------------------------------------------------
package tsdt_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_TICKS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CEILING    = 2'd2;

    localparam logic [31:0] MIN_TICKS_RESET = 32'd1;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd4;
    localparam logic [7:0]  CEILING_RESET   = 8'd8;

    localparam logic [1:0] MODE_OBSERVE        = 2'd0;
    localparam logic [1:0] MODE_QUERY          = 2'd1;
    localparam logic [1:0] MODE_FORGET_THREAD  = 2'd2;
    localparam logic [1:0] MODE_FORGET_PROCESS = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] process;
        logic [63:0] thread_id;
        logic [63:0] ticks_used;
        logic [63:0] calls_made;
    } in_beat_t;

    typedef struct packed {
        logic       serialize;
        logic [7:0] score;
        logic       status;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] process;
        logic [63:0] thread;
        logic [7:0]  score;
    } entry_t;

    typedef struct packed {
        logic load_lo;
        logic load_hi;
    } dense_ctrl_t;

endpackage

[rtl/thread_syscall_density_table_core.sv]
// ----------------------------------------------------------------------------
// thread_syscall_density_table_core
// Per-thread syscall density table: observe, query and forget operations.
// ----------------------------------------------------------------------------
// One item is handled at a time: the input is ready only in the idle
// state, and an item is done once its result is loaded into the output
// register, which waits for out_ready. The scan reads the entry RAM through
// its single read port, one entry per cycle, with registered read data, and
// then closes; it is followed by an update state (S_DECIDE), a result state
// (S_DONE) and the idle state with the input ready.
// Valid bits sit in flip-flops and are cleared by reset at once, so no
// clearing pass is needed. A new entry takes the lowest-numbered free slot;
// a full table drops the insert and reports status 1.
module thread_syscall_density_table_core #(
    parameter int TABLE_ENTRIES = tsdt_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tsdt_pkg::in_beat_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tsdt_pkg::out_beat_t                out_data,
    input  logic                               cfg_write,
    input  logic [tsdt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tsdt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]               state_reg, state_next;
    tsdt_pkg::in_beat_t       item_reg, item_next;
    logic [CW-1:0]            iss_reg, iss_next;
    logic                     pv_reg, pv_next;
    logic [IW-1:0]            pidx_reg, pidx_next;
    logic                     found_reg, found_next;
    logic [IW-1:0]            slot_reg, slot_next;
    logic [7:0]               fscore_reg, fscore_next;
    logic                     free_found_reg, free_found_next;
    logic [IW-1:0]            free_reg, free_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    tsdt_pkg::out_beat_t      res_reg, res_next;
    tsdt_pkg::out_beat_t      out_data_reg, out_data_next;
    logic                     out_valid_reg, out_valid_next;
    logic [31:0]              min_reg, min_next;
    logic [7:0]               thresh_reg, thresh_next;
    logic [7:0]               ceil_reg, ceil_next;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    tsdt_pkg::entry_t         wr_data;
    tsdt_pkg::entry_t         rd_data;
    tsdt_pkg::dense_ctrl_t    dense_ctrl;
    logic                     dense;

    logic                     accept;
    logic                     out_load;
    logic                     entry_live;
    logic                     proc_hit;
    logic                     key_hit;
    logic [7:0]               sat_base;
    logic [8:0]               sat_sum;
    logic [7:0]               sat_score;
    logic                     res_exists;
    logic [7:0]               res_score;
    logic                     res_status;

    tsdt_ram #(
        .WIDTH ($bits(tsdt_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (iss_reg[IW-1:0]),
        .rdata (rd_data)
    );

    assign dense_ctrl.load_lo = (state_reg == S_SCAN) && (iss_reg == CW'(0));
    assign dense_ctrl.load_hi = (state_reg == S_SCAN) && (iss_reg == CW'(1));

    tsdt_dense u_dense (
        .clk       (clk),
        .ctrl      (dense_ctrl),
        .min_ticks (min_reg),
        .ticks     (item_reg.ticks_used),
        .calls     (item_reg.calls_made),
        .dense     (dense)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign entry_live = valid_reg[pidx_reg];
    assign proc_hit   = entry_live && (rd_data.process == item_reg.process);
    assign key_hit    = proc_hit && (rd_data.thread == item_reg.thread_id);

    assign sat_base  = found_reg ? fscore_reg : 8'd0;
    assign sat_sum   = {1'b0, sat_base} + 9'd1;
    assign sat_score = (sat_sum > {1'b0, ceil_reg}) ? ceil_reg : sat_sum[7:0];

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        iss_next        = iss_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        fscore_next     = fscore_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        min_next        = min_reg;
        thresh_next     = thresh_reg;
        ceil_next       = ceil_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = '{process: item_reg.process, thread: item_reg.thread_id,
                            score: sat_score};
        res_exists      = 1'b0;
        res_score       = 8'd0;
        res_status      = tsdt_pkg::STATUS_OK;

        if (cfg_write)
        begin
            case (cfg_index)
                tsdt_pkg::CFG_MIN_TICKS: min_next    = cfg_data[31:0];
                tsdt_pkg::CFG_THRESHOLD: thresh_next = cfg_data[7:0];
                tsdt_pkg::CFG_CEILING:   ceil_next   = cfg_data[7:0];
                default:                 ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next       = in_data;
                    iss_next        = '0;
                    pv_next         = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (iss_reg < CW'(TABLE_ENTRIES))
                begin
                    pv_next   = 1'b1;
                    pidx_next = iss_reg[IW-1:0];
                    iss_next  = iss_reg + CW'(1);
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg)
                begin
                    if (key_hit && !found_reg)
                    begin
                        found_next  = 1'b1;
                        slot_next   = pidx_reg;
                        fscore_next = rd_data.score;
                    end
                    if (!entry_live && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_next       = pidx_reg;
                    end
                    if (proc_hit && (item_reg.mode == tsdt_pkg::MODE_FORGET_PROCESS))
                    begin
                        valid_next[pidx_reg] = 1'b0;
                    end
                end
                if ((iss_reg == CW'(TABLE_ENTRIES)) && !pv_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (item_reg.mode)
                    tsdt_pkg::MODE_OBSERVE:
                    begin
                        if (dense)
                        begin
                            if (found_reg)
                            begin
                                wr_en      = 1'b1;
                                res_exists = 1'b1;
                                res_score  = sat_score;
                            end
                            else if (free_found_reg)
                            begin
                                wr_en               = 1'b1;
                                wr_addr             = free_reg;
                                valid_next[free_reg] = 1'b1;
                                res_exists          = 1'b1;
                                res_score           = sat_score;
                            end
                            else
                            begin
                                res_status = tsdt_pkg::STATUS_FULL;
                            end
                        end
                        else if (found_reg)
                        begin
                            if (fscore_reg > 8'd1)
                            begin
                                wr_en         = 1'b1;
                                wr_data.score = fscore_reg - 8'd1;
                                res_exists    = 1'b1;
                                res_score     = fscore_reg - 8'd1;
                            end
                            else
                            begin
                                valid_next[slot_reg] = 1'b0;
                            end
                        end
                    end
                    tsdt_pkg::MODE_QUERY:
                    begin
                        res_exists = found_reg;
                        res_score  = found_reg ? fscore_reg : 8'd0;
                    end
                    tsdt_pkg::MODE_FORGET_THREAD:
                    begin
                        if (found_reg)
                        begin
                            valid_next[slot_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                res_next.serialize = res_exists && (res_score >= thresh_reg);
                res_next.score     = res_score;
                res_next.status    = res_status;
                state_next         = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            iss_reg        <= '0;
            min_reg        <= tsdt_pkg::MIN_TICKS_RESET;
            thresh_reg     <= tsdt_pkg::THRESHOLD_RESET;
            ceil_reg       <= tsdt_pkg::CEILING_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            pv_reg         <= pv_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            iss_reg        <= iss_next;
            min_reg        <= min_next;
            thresh_reg     <= thresh_next;
            ceil_reg       <= ceil_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pidx_reg     <= pidx_next;
        slot_reg     <= slot_next;
        fscore_reg   <= fscore_next;
        free_reg     <= free_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/tsdt_ram.sv]
// ----------------------------------------------------------------------------
// tsdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tsdt_dense.sv]
// ----------------------------------------------------------------------------
// tsdt_dense
// Density test: ticks < minimum * calls, product built from two 32x32 steps.
// ----------------------------------------------------------------------------
module tsdt_dense (
    input  logic                  clk,
    input  tsdt_pkg::dense_ctrl_t ctrl,
    input  logic [31:0]           min_ticks,
    input  logic [63:0]           ticks,
    input  logic [63:0]           calls,
    output logic                  dense
);

    logic [31:0] operand;
    logic [63:0] part;
    logic [63:0] lo_reg;
    logic [63:0] hi_reg;
    logic [95:0] product;

    assign operand = ctrl.load_hi ? calls[63:32] : calls[31:0];
    assign part    = 64'(min_ticks) * 64'(operand);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_lo)
        begin
            lo_reg <= part;
        end
        if (ctrl.load_hi)
        begin
            hi_reg <= part;
        end
    end

    assign product = {hi_reg, 32'd0} + {32'd0, lo_reg};
    assign dense   = (calls != 64'd0) && ({32'd0, ticks} < product);

endmodule

[bench/thread_syscall_density_table_core_tb.sv]
// ----------------------------------------------------------------------------
// thread_syscall_density_table_core_tb
// Self-checking bench for the syscall density table. A scoreboard class keeps
// its own copy of the table and the registers, predicts the single reply of
// every accepted request beat and checks replies in order, field by field.
// A directed opening covers the key corners; random traffic over a small key
// pool then runs under several register settings, with random gaps on both
// channels, a burst-only stretch and one long output stall.
// ----------------------------------------------------------------------------
module thread_syscall_density_table_core_tb;

    localparam int ENTRIES = tsdt_pkg::TABLE_ENTRIES_DEFAULT;
    localparam logic [tsdt_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int HOLD_AT_REPLY = 300;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 1000000;

    class density_scoreboard;
        logic [31:0]         min_ticks;
        logic [7:0]          threshold;
        logic [7:0]          ceiling;
        bit                  live [ENTRIES];
        logic [31:0]         owner [ENTRIES];
        logic [63:0]         tid [ENTRIES];
        logic [7:0]          level [ENTRIES];
        tsdt_pkg::out_beat_t replies [$];
        int                  errors;
        int                  checked;

        function new();
            min_ticks = tsdt_pkg::MIN_TICKS_RESET;
            threshold = tsdt_pkg::THRESHOLD_RESET;
            ceiling = tsdt_pkg::CEILING_RESET;
            foreach (live[i]) live[i] = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [tsdt_pkg::CFG_INDEX_W-1:0] index,
                                logic [tsdt_pkg::CFG_DATA_W-1:0] value);
            case (index)
                tsdt_pkg::CFG_MIN_TICKS: min_ticks = value;
                tsdt_pkg::CFG_THRESHOLD: threshold = value[7:0];
                tsdt_pkg::CFG_CEILING:   ceiling = value[7:0];
                default: ;
            endcase
        endfunction

        function int find_key(logic [31:0] pid, logic [63:0] thread_key);
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && owner[i] == pid && tid[i] == thread_key)
                    return i;
            return -1;
        endfunction

        function int first_free();
            for (int i = 0; i < ENTRIES; i++)
                if (!live[i])
                    return i;
            return -1;
        endfunction

        function void note_request(tsdt_pkg::in_beat_t beat);
            int slot;
            logic [8:0] raised;
            tsdt_pkg::out_beat_t reply;
            slot = find_key(beat.process, beat.thread_id);
            reply.serialize = 1'b0;
            reply.score = 8'd0;
            reply.status = tsdt_pkg::STATUS_OK;
            case (beat.mode)
                tsdt_pkg::MODE_OBSERVE:
                begin
                    if (beat.calls_made != 64'd0 &&
                        (beat.ticks_used / beat.calls_made) < {32'd0, min_ticks})
                    begin
                        if (slot < 0)
                        begin
                            slot = first_free();
                            if (slot >= 0)
                            begin
                                live[slot] = 1'b1;
                                owner[slot] = beat.process;
                                tid[slot] = beat.thread_id;
                                level[slot] = 8'd0;
                            end
                            else
                            begin
                                reply.status = tsdt_pkg::STATUS_FULL;
                            end
                        end
                        if (slot >= 0)
                        begin
                            raised = {1'b0, level[slot]} + 9'd1;
                            if (raised > {1'b0, ceiling})
                                raised = {1'b0, ceiling};
                            level[slot] = raised[7:0];
                        end
                    end
                    else if (slot >= 0)
                    begin
                        if (level[slot] > 8'd1)
                        begin
                            level[slot] = level[slot] - 8'd1;
                        end
                        else
                        begin
                            live[slot] = 1'b0;
                            slot = -1;
                        end
                    end
                end
                tsdt_pkg::MODE_FORGET_THREAD:
                begin
                    if (slot >= 0)
                        live[slot] = 1'b0;
                    slot = -1;
                end
                tsdt_pkg::MODE_FORGET_PROCESS:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (live[i] && owner[i] == beat.process)
                            live[i] = 1'b0;
                    slot = -1;
                end
                default: ;
            endcase
            if (slot >= 0)
            begin
                reply.serialize = (level[slot] >= threshold);
                reply.score = level[slot];
            end
            replies.push_back(reply);
        endfunction

        task report(string what);
            $display("mismatch at reply %0d: %s", checked, what);
            errors++;
        endtask

        task check_reply(tsdt_pkg::out_beat_t got);
            tsdt_pkg::out_beat_t want;
            if (replies.size() == 0)
            begin
                report($sformatf("reply %h with no request waiting", got));
            end
            else
            begin
                want = replies.pop_front();
                if (got.serialize !== want.serialize)
                    report($sformatf("serialize %b, want %b", got.serialize, want.serialize));
                if (got.score !== want.score)
                    report($sformatf("score %0d, want %0d", got.score, want.score));
                if (got.status !== want.status)
                    report($sformatf("status %b, want %b", got.status, want.status));
            end
            checked++;
        endtask
    endclass

    logic                                 clk;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    tsdt_pkg::in_beat_t                   in_data = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    tsdt_pkg::out_beat_t                  out_data;
    logic                                 cfg_write = 1'b0;
    logic [tsdt_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [tsdt_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    density_scoreboard density_sb;
    int tx_gap_max = 1;
    int rx_gap_max = 1;
    int cycles = 0;

    thread_syscall_density_table_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("thread_syscall_density_table_core_tb: errors");
        $finish;
    end

    function automatic tsdt_pkg::in_beat_t make_request(logic [1:0] mode, logic [31:0] pid,
                                                        logic [63:0] thread_key,
                                                        logic [63:0] ticks,
                                                        logic [63:0] calls);
        tsdt_pkg::in_beat_t beat;
        beat.mode = mode;
        beat.process = pid;
        beat.thread_id = thread_key;
        beat.ticks_used = ticks;
        beat.calls_made = calls;
        return beat;
    endfunction

    function automatic tsdt_pkg::in_beat_t random_request(bit calm);
        tsdt_pkg::in_beat_t beat;
        int pick;
        int lean;
        logic [3:0] nib;
        logic [63:0] ratio;
        logic [5:0] span;
        pick = $urandom_range(0, 99);
        if (calm)
            beat.mode = pick < 88 ? tsdt_pkg::MODE_OBSERVE :
                        pick < 94 ? tsdt_pkg::MODE_QUERY :
                        pick < 98 ? tsdt_pkg::MODE_FORGET_THREAD :
                        tsdt_pkg::MODE_FORGET_PROCESS;
        else
            beat.mode = pick < 70 ? tsdt_pkg::MODE_OBSERVE :
                        pick < 84 ? tsdt_pkg::MODE_QUERY :
                        pick < 94 ? tsdt_pkg::MODE_FORGET_THREAD :
                        tsdt_pkg::MODE_FORGET_PROCESS;
        if ($urandom_range(0, 9) == 0)
        begin
            beat.process = $urandom;
            beat.thread_id = {$urandom, $urandom};
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: nib = 4'h0;
                1: nib = 4'h3;
                2: nib = 4'h5;
                3: nib = 4'ha;
                default: nib = 4'hf;
            endcase
            beat.process = {8{nib}};
            nib = 4'($urandom_range(0, 15));
            beat.thread_id = {16{nib}};
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            beat.calls_made = 64'd0;
        else if (pick == 1)
            beat.calls_made = {$urandom, $urandom};
        else
            beat.calls_made = 64'($urandom_range(1, 40));
        if ($urandom_range(0, 9) == 0)
        begin
            beat.ticks_used = {$urandom, $urandom};
        end
        else
        begin
            lean = calm ? 95 : 55;
            ratio = {32'd0, density_sb.min_ticks};
            if ($urandom_range(0, 99) < lean && ratio != 64'd0)
                ratio = ratio - 64'd1;
            beat.ticks_used = beat.calls_made * ratio;
            if (beat.calls_made != 64'd0 && beat.calls_made < 64'd41)
            begin
                span = beat.calls_made[5:0] - 6'd1;
                beat.ticks_used = beat.ticks_used + 64'($urandom_range(0, span));
            end
        end
        return beat;
    endfunction

    task automatic send_request(input tsdt_pkg::in_beat_t beat);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        density_sb.note_request(beat);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (density_sb.replies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [tsdt_pkg::CFG_INDEX_W-1:0] index,
                           input logic [tsdt_pkg::CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        density_sb.write_reg(index, value);
    endtask

    task automatic load_settings(input logic [31:0] min_ticks, input logic [7:0] threshold,
                                 input logic [7:0] ceiling);
        logic [31:0] junk;
        junk = $urandom;
        put_reg(tsdt_pkg::CFG_MIN_TICKS, min_ticks);
        put_reg(tsdt_pkg::CFG_THRESHOLD, {junk[31:8], threshold});
        put_reg(tsdt_pkg::CFG_CEILING, {junk[23:0], ceiling});
        put_reg(CFG_SPARE, $urandom);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : reply_sink
        int gap;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            density_sb.check_reply(out_data);
            taken++;
            // hold off long enough for the input side to back up
            if (taken == HOLD_AT_REPLY)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] min_ticks;
        logic [7:0]  threshold;
        logic [7:0]  ceiling;
        bit          calm;
        density_sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(tsdt_pkg::MODE_QUERY, 32'd0, 64'd0, 64'd0, 64'd0));
        send_request(make_request(tsdt_pkg::MODE_OBSERVE, 32'd0, 64'd0, 64'd0, 64'd1));
        send_request(make_request(tsdt_pkg::MODE_OBSERVE, 32'd0, 64'd0, 64'd5, 64'd0));
        send_request(make_request(tsdt_pkg::MODE_QUERY, 32'd0, 64'd0, 64'd0, 64'd0));
        // climb past the threshold into saturation
        repeat (9)
            send_request(make_request(tsdt_pkg::MODE_OBSERVE, '1, '1, 64'd0, '1));
        send_request(make_request(tsdt_pkg::MODE_OBSERVE, '1, '1, '1, 64'd1));
        send_request(make_request(tsdt_pkg::MODE_OBSERVE, '1, '1, '1, '1));
        send_request(make_request(tsdt_pkg::MODE_QUERY, '1, '1, 64'd0, 64'd0));
        send_request(make_request(tsdt_pkg::MODE_FORGET_THREAD, '1, '1, '1, '1));
        send_request(make_request(tsdt_pkg::MODE_QUERY, '1, '1, 64'd0, 64'd0));
        send_request(make_request(tsdt_pkg::MODE_OBSERVE, 32'd5, 64'd1, 64'd0, 64'd3));
        send_request(make_request(tsdt_pkg::MODE_OBSERVE, 32'd5, 64'd2, 64'd0, 64'd3));
        send_request(make_request(tsdt_pkg::MODE_OBSERVE, 32'd6, 64'd1, 64'd0, 64'd3));
        send_request(make_request(tsdt_pkg::MODE_FORGET_PROCESS, 32'd5, '1, '1, '1));
        send_request(make_request(tsdt_pkg::MODE_QUERY, 32'd5, 64'd2, 64'd0, 64'd0));
        send_request(make_request(tsdt_pkg::MODE_QUERY, 32'd6, 64'd1, 64'd0, 64'd0));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_replies();
            case (ph)
                0:
                begin
                    min_ticks = 32'd1;  threshold = 8'd4;   ceiling = 8'd8;
                    tx_gap_max = 3;     rx_gap_max = 3;     calm = 1'b0;
                end
                1:
                begin
                    min_ticks = 32'd5;  threshold = 8'd0;   ceiling = 8'd0;
                    tx_gap_max = 0;     rx_gap_max = 0;     calm = 1'b0;
                end
                2:
                begin
                    min_ticks = 32'd0;  threshold = 8'd255; ceiling = 8'd255;
                    tx_gap_max = 3;     rx_gap_max = 0;     calm = 1'b0;
                end
                3:
                begin
                    min_ticks = '1;     threshold = 8'd255; ceiling = 8'd255;
                    tx_gap_max = 1;     rx_gap_max = 3;     calm = 1'b1;
                end
                4:
                begin
                    min_ticks = 32'd3;  threshold = 8'd2;   ceiling = 8'd5;
                    tx_gap_max = 3;     rx_gap_max = 3;     calm = 1'b1;
                end
                5:
                begin
                    min_ticks = 32'd1;  threshold = 8'd1;   ceiling = 8'd1;
                    tx_gap_max = 2;     rx_gap_max = 1;     calm = 1'b0;
                end
                6:
                begin
                    min_ticks = $urandom_range(1, 1000);
                    threshold = 8'($urandom); ceiling = 8'($urandom);
                    tx_gap_max = 3;     rx_gap_max = 3;     calm = 1'b0;
                end
                default:
                begin
                    min_ticks = 32'd2;  threshold = 8'd0;   ceiling = 8'd255;
                    tx_gap_max = 0;     rx_gap_max = 3;     calm = 1'b1;
                end
            endcase
            load_settings(min_ticks, threshold, ceiling);
            repeat (ITEMS_PER_PHASE)
                send_request(random_request(calm));
        end
        drain_replies();

        if (density_sb.errors == 0)
            $display("thread_syscall_density_table_core_tb: clean");
        else
            $display("thread_syscall_density_table_core_tb: errors");
        $finish;
    end
endmodule
